@@ rtl/crcdf_pkg.sv @@
// Shared constants, types and the CRC-32 byte step for the request deframer.
// No dependencies; every other file in the block refers to this package.
package crcdf_pkg;

   // Frame length default and the layout of a frame.
   localparam int FRAME_BYTES_DEF = 10;
   localparam int OP_POS          = 1;
   localparam int ARG_LO_POS      = 2;
   localparam int ARG_HI_POS      = 3;
   localparam int SEQ_LO_POS      = 4;
   localparam int SEQ_HI_POS      = 5;
   localparam int CRC_SPAN        = 6;
   localparam int CRC_POS         = 6;
   localparam int CRC_LAST_POS    = 9;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ALL  = 32'hFFFF_FFFF;

   // Register file.
   localparam int          CSR_INDEX_W     = 2;
   localparam int          CSR_DATA_W      = 32;
   localparam logic [1:0]  REG_MAGIC_BYTE  = 2'd0;
   localparam logic [1:0]  REG_HIGH_ARG_OP = 2'd1;
   localparam logic [1:0]  REG_TIMEOUT     = 2'd2;
   localparam logic [31:0] TIMEOUT_RESET   = 32'd24_000_000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_byte;
      logic take_tick;
      logic rd_en;
      logic rd_copy;
      logic bad_crc;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tick;
      logic frame_done;
      logic crc_ok;
      logic found;
      logic out_free;
   } status_type;

   // One byte of the reflected CRC-32, one bit step per loop pass.
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ rtl/crc_checked_request_deframer.sv @@
// Top level of the CRC-checked request deframer.
// Depends on crcdf_pkg, crcdf_ctrl and crcdf_datapath.

// Byte-serial request deframer. Each request carries either one received byte
// (req_action low) or one tick of time (req_action high). A tick, and a byte
// that does not end a frame, leave the controller idle. The byte that completes
// a frame of FRAME_BYTES bytes starts a pass of the controller over the frame
// store, which has one read port and is read one byte per cycle: a scan for the
// CRC-32, the fields and the first later magic byte, then a state to drain the
// read and one to check. A good frame then loads the result register, waiting
// while an earlier result has not been taken. A bad frame that holds a later
// magic byte at position p copies the remaining FRAME_BYTES - p bytes to the
// front, one per cycle, then drains the last read. Configuration is written
// through csr_* with no wait and is meant to change only while the block is
// idle.
module crc_checked_request_deframer #(
   parameter int FRAME_BYTES = crcdf_pkg::FRAME_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [crcdf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [crcdf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_opcode,
   output logic [31:0]                       rsp_argument,
   output logic [15:0]                       rsp_sequence_number
);

   localparam int IDX_W = $clog2(FRAME_BYTES);

   crcdf_pkg::cmd_type    cmd;
   crcdf_pkg::status_type st;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      first_pos;

   crcdf_ctrl #(
      .FRAME_BYTES (FRAME_BYTES),
      .IDX_W       (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .first_pos (first_pos),
      .cmd       (cmd),
      .rd_addr   (rd_addr)
   );

   crcdf_datapath #(
      .FRAME_BYTES (FRAME_BYTES),
      .IDX_W       (IDX_W)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_action          (req_action),
      .req_rx_byte         (req_rx_byte),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_opcode          (rsp_opcode),
      .rsp_argument        (rsp_argument),
      .rsp_sequence_number (rsp_sequence_number),
      .cmd                 (cmd),
      .rd_addr             (rd_addr),
      .st                  (st),
      .first_pos           (first_pos)
   );

endmodule

@@ rtl/crcdf_ctrl.sv @@
// Controller state machine of the request deframer.
// Depends on crcdf_pkg; drives crcdf_datapath through command and status structs.
module crcdf_ctrl #(
   parameter int FRAME_BYTES = crcdf_pkg::FRAME_BYTES_DEF,
   parameter int IDX_W       = $clog2(FRAME_BYTES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  crcdf_pkg::status_type st,
   input  logic [IDX_W-1:0]      first_pos,
   output crcdf_pkg::cmd_type    cmd,
   output logic [IDX_W-1:0]      rd_addr
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_DRAIN,
      ST_CHECK,
      ST_EMIT,
      ST_MOVE,
      ST_MOVE_DRAIN
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

   state_type        state_ff;
   logic [IDX_W-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.take_byte && st.frame_done) begin
                  state_ff <= ST_SCAN;
                  cnt_ff   <= '0;
               end
            end
            ST_SCAN: begin
               if (cnt_ff == LAST_IDX) begin
                  state_ff <= ST_SCAN_DRAIN;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_SCAN_DRAIN: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               priority if (st.crc_ok) begin
                  state_ff <= ST_EMIT;
               end else if (st.found) begin
                  // Resync: copy the tail that starts at the first magic byte after the head.
                  state_ff <= ST_MOVE;
                  cnt_ff   <= first_pos;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_EMIT: begin
               if (st.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_MOVE: begin
               if (cnt_ff == LAST_IDX) begin
                  state_ff <= ST_MOVE_DRAIN;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_MOVE_DRAIN: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rd_addr       = cnt_ff;
   assign cmd.take_byte = req_valid && req_ready && !st.is_tick;
   assign cmd.take_tick = req_valid && req_ready && st.is_tick;
   assign cmd.rd_en     = (state_ff == ST_SCAN) || (state_ff == ST_MOVE);
   assign cmd.rd_copy   = (state_ff == ST_MOVE);
   assign cmd.bad_crc   = (state_ff == ST_CHECK) && !st.crc_ok;
   assign cmd.emit      = (state_ff == ST_EMIT) && st.out_free;

`ifndef ASSERT_OFF
   a_emit_needs_free_output: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> st.out_free)
      else $error("result loaded while the output register was still full");

   a_frame_end_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_byte && st.frame_done) |=> (cmd.rd_en && !cmd.rd_copy && rd_addr == '0))
      else $error("completed frame did not start the store scan at byte zero");

   a_bad_without_magic_resumes: assert property (@(posedge clock) disable iff (reset)
      (cmd.bad_crc && !st.found) |=> req_ready)
      else $error("bad frame without a magic byte did not return to hunting");
`endif

endmodule

@@ rtl/crcdf_datapath.sv @@
// Datapath of the request deframer: frame store, CRC, timeout, registers, output.
// Depends on crcdf_pkg; commanded by crcdf_ctrl.
module crcdf_datapath #(
   parameter int FRAME_BYTES = crcdf_pkg::FRAME_BYTES_DEF,
   parameter int IDX_W       = $clog2(FRAME_BYTES)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [crcdf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [crcdf_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                req_action,
   input  logic [7:0]                          req_rx_byte,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [7:0]                          rsp_opcode,
   output logic [31:0]                         rsp_argument,
   output logic [15:0]                         rsp_sequence_number,
   input  crcdf_pkg::cmd_type                  cmd,
   input  logic [IDX_W-1:0]                    rd_addr,
   output crcdf_pkg::status_type               st,
   output logic [IDX_W-1:0]                    first_pos
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

   // Configuration registers.
   logic [7:0]  magic_ff;
   logic [7:0]  high_op_ff;
   logic [31:0] timeout_ff;

   // Control state.
   logic [IDX_W-1:0] fill_ff;
   logic [15:0]      high_half_ff;
   logic [31:0]      idle_ff;
   logic             rd_vld_ff;
   logic             found_ff;
   logic             rsp_valid_ff;

   // Frame store and scan results.
   logic [7:0]       frame_mem_ff [FRAME_BYTES];
   logic [7:0]       rd_data_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rd_copy_ff;
   logic [IDX_W-1:0] first_ff;
   logic [31:0]      crc_ff;
   logic [31:0]      rx_crc_ff;
   logic [7:0]       op_ff;
   logic [15:0]      arg_ff;
   logic [15:0]      seq_ff;
   logic [7:0]       rsp_opcode_ff;
   logic [31:0]      rsp_argument_ff;
   logic [15:0]      rsp_seq_ff;

   logic             store_byte;
   logic             scan_step;
   logic             copy_step;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic [31:0]      idle_in;
   logic [IDX_W:0]   tail_len;

   assign store_byte = cmd.take_byte && ((fill_ff != '0) || (req_rx_byte == magic_ff));
   assign scan_step  = rd_vld_ff && !rd_copy_ff;
   assign copy_step  = rd_vld_ff && rd_copy_ff;
   assign idle_in    = (idle_ff == crcdf_pkg::CRC_ALL) ? idle_ff : idle_ff + 32'd1;
   assign tail_len   = (IDX_W + 1)'(FRAME_BYTES) - {1'b0, first_ff};

   // One write port shared by incoming bytes and the resync copy.
   always_comb begin
      wr_en   = store_byte || copy_step;
      wr_addr = store_byte ? fill_ff : (rd_idx_ff - first_ff);
      wr_data = store_byte ? req_rx_byte : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= frame_mem_ff[rd_addr];
         rd_idx_ff  <= rd_addr;
         rd_copy_ff <= cmd.rd_copy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= '0;
         high_op_ff <= '0;
         timeout_ff <= crcdf_pkg::TIMEOUT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            crcdf_pkg::REG_MAGIC_BYTE:  magic_ff   <= csr_wdata[7:0];
            crcdf_pkg::REG_HIGH_ARG_OP: high_op_ff <= csr_wdata[7:0];
            crcdf_pkg::REG_TIMEOUT:     timeout_ff <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         high_half_ff <= '0;
         idle_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
         if (cmd.take_tick) begin
            idle_ff <= idle_in;
            if ((fill_ff != '0) && (idle_in > timeout_ff)) begin
               fill_ff      <= '0;
               high_half_ff <= '0;
            end
         end
         if (cmd.take_byte) begin
            idle_ff <= '0;
         end
         if (store_byte) begin
            if (fill_ff == LAST_IDX) begin
               fill_ff  <= '0;
               found_ff <= 1'b0;
            end else begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         if (scan_step && !found_ff && (rd_idx_ff != '0) && (rd_data_ff == magic_ff)) begin
            found_ff <= 1'b1;
         end
         if (cmd.bad_crc) begin
            high_half_ff <= '0;
            fill_ff      <= found_ff ? tail_len[IDX_W-1:0] : '0;
         end
         if (cmd.emit) begin
            high_half_ff <= (op_ff == high_op_ff) ? arg_ff : 16'd0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Field capture and CRC accumulation as the scan walks the store, and the result load.
   always_ff @(posedge clock) begin
      if (store_byte && (fill_ff == LAST_IDX)) begin
         crc_ff <= crcdf_pkg::CRC_ALL;
      end
      if (scan_step) begin
         if (rd_idx_ff < IDX_W'(crcdf_pkg::CRC_SPAN)) begin
            crc_ff <= crcdf_pkg::crc32_byte(crc_ff, rd_data_ff);
         end
         if (rd_idx_ff == IDX_W'(crcdf_pkg::OP_POS)) begin
            op_ff <= rd_data_ff;
         end
         if (rd_idx_ff == IDX_W'(crcdf_pkg::ARG_LO_POS)) begin
            arg_ff[7:0] <= rd_data_ff;
         end
         if (rd_idx_ff == IDX_W'(crcdf_pkg::ARG_HI_POS)) begin
            arg_ff[15:8] <= rd_data_ff;
         end
         if (rd_idx_ff == IDX_W'(crcdf_pkg::SEQ_LO_POS)) begin
            seq_ff[7:0] <= rd_data_ff;
         end
         if (rd_idx_ff == IDX_W'(crcdf_pkg::SEQ_HI_POS)) begin
            seq_ff[15:8] <= rd_data_ff;
         end
         // The received CRC is little-endian, so bytes shift in from the top.
         if ((rd_idx_ff >= IDX_W'(crcdf_pkg::CRC_POS)) &&
             (rd_idx_ff <= IDX_W'(crcdf_pkg::CRC_LAST_POS))) begin
            rx_crc_ff <= {rd_data_ff, rx_crc_ff[31:8]};
         end
         if (!found_ff && (rd_idx_ff != '0) && (rd_data_ff == magic_ff)) begin
            first_ff <= rd_idx_ff;
         end
      end
      if (cmd.emit) begin
         rsp_opcode_ff   <= op_ff;
         rsp_argument_ff <= {high_half_ff, arg_ff};
         rsp_seq_ff      <= seq_ff;
      end
   end

   assign st.is_tick    = req_action;
   assign st.frame_done = !req_action && (fill_ff == LAST_IDX);
   assign st.crc_ok     = ((crc_ff ^ crcdf_pkg::CRC_ALL) == rx_crc_ff);
   assign st.found      = found_ff;
   assign st.out_free   = !rsp_valid_ff || rsp_ready;
   assign first_pos     = first_ff;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_opcode          = rsp_opcode_ff;
   assign rsp_argument        = rsp_argument_ff;
   assign rsp_sequence_number = rsp_seq_ff;

`ifndef ASSERT_OFF
   a_single_write_source: assert property (@(posedge clock) disable iff (reset)
      !(store_byte && copy_step))
      else $error("incoming byte and resync copy wrote the store in the same cycle");

   a_fill_below_frame: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LAST_IDX)
      else $error("fill count reached the frame length");

   a_first_magic_past_head: assert property (@(posedge clock) disable iff (reset)
      (cmd.bad_crc && found_ff) |-> (first_ff != '0))
      else $error("resync position points at the head byte");
`endif

endmodule
